### sv/dstq_pkg.sv
package dstq_pkg;

  localparam int IN_TIME_W = 48;
  localparam int ID_W      = 31;
  localparam int HND_W     = 16;
  localparam int ND_W      = 49;
  localparam int MAX_OUT   = 16;
  localparam int CNT_W     = 5;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  typedef enum logic [1:0] {
    KIND_ADDED = 2'd0,
    KIND_DUE   = 2'd1,
    KIND_NONE  = 2'd2,
    KIND_FULL  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD_CMP,
    ST_ADD_INS,
    ST_POLL
  } state_t;

  typedef struct packed {
    logic load;
    logic cmp;
    logic insert;
    logic reject;
    logic pop;
    logic pop_last;
    logic none_due;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic head_due;
    logic next_due;
  } dp_stat_t;

endpackage

### sv/deadline_sorted_timer_queue_top.sv
// Sorted timer queue: up to DEPTH entries ordered by deadline, ties in
// arrival order.
// Input: drive cmd, deadline, handle and now_time with start high; the item
// is taken on a clock edge where start is high and busy is low. cmd 0 adds
// an entry, cmd 1 polls for entries due at now_time.
// Results: each result shows for one cycle with strobe high; the receiver
// cannot hold them off. last marks the final result of an item.
// Sequence: an add passes a compare step, an insert step and the output
// register, and is busy during compare and insert; an add to a full queue
// skips the insert and gives its result from the compare step. A poll
// pops one due head entry per cycle, at most 16 per poll, and is busy until
// the drain ends. The compare across all slots and the shifting row of slot
// cells set this sequence.
// Reset: rst clears the control state, the occupancy, the id counter and
// the strobe; the slot contents need no clearing.
module deadline_sorted_timer_queue_top #(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cmd,
  input  logic [47:0]          deadline,
  input  logic [15:0]          handle,
  input  logic [47:0]          now_time,
  output logic                 strobe,
  output logic [1:0]           kind,
  output logic [30:0]          entry_id,
  output logic [15:0]          entry_handle,
  output logic signed [48:0]   next_deadline,
  output logic                 last
);
  import dstq_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t stat;

  dstq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  dstq_datapath #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .deadline      (deadline),
    .handle        (handle),
    .now_time      (now_time),
    .strobe        (strobe),
    .kind          (kind),
    .entry_id      (entry_id),
    .entry_handle  (entry_handle),
    .next_deadline (next_deadline),
    .last          (last)
  );

endmodule

### sv/dstq_datapath.sv
module dstq_datapath #(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dstq_pkg::dp_cmd_t                   ctl,
  output dstq_pkg::dp_stat_t                  stat,
  input  logic [dstq_pkg::IN_TIME_W-1:0]      deadline,
  input  logic [dstq_pkg::HND_W-1:0]          handle,
  input  logic [dstq_pkg::IN_TIME_W-1:0]      now_time,
  output logic                                strobe,
  output logic [1:0]                          kind,
  output logic [dstq_pkg::ID_W-1:0]           entry_id,
  output logic [dstq_pkg::HND_W-1:0]          entry_handle,
  output logic signed [dstq_pkg::ND_W-1:0]    next_deadline,
  output logic                                last
);
  import dstq_pkg::*;

  localparam int TW    = (TIME_BITS < IN_TIME_W) ? TIME_BITS : IN_TIME_W;
  localparam int OCC_W = $clog2(DEPTH + 1);

  logic [TW-1:0]    slot_dl  [DEPTH];
  logic [HND_W-1:0] slot_hnd [DEPTH];
  logic [ID_W-1:0]  slot_id  [DEPTH];
  logic [OCC_W-1:0] occ;
  logic [ID_W-1:0]  id_counter;
  logic [TW-1:0]    in_dl;
  logic [TW-1:0]    in_now;
  logic [HND_W-1:0] in_hnd;
  logic [DEPTH-1:0] le;
  logic [DEPTH-1:0] le_next;
  logic [ID_W-1:0]  nid_raw;
  logic [ID_W-1:0]  nid;
  logic [ND_W-1:0]  head_nd;
  logic [ND_W-1:0] second_nd;

  // Valid slots form a sorted prefix, so the matches form a prefix too
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le_next[i] = (OCC_W'(i) < occ) && (slot_dl[i] <= in_dl);
    end
  end

  assign nid_raw   = id_counter + ID_W'(1);
  assign nid       = (nid_raw == '0) ? ID_W'(1) : nid_raw;
  assign head_nd   = (occ == '0) ? '1 : ND_W'(slot_dl[0]);
  assign second_nd = (occ > OCC_W'(1)) ? ND_W'(slot_dl[1]) : '1;

  assign stat.full     = (occ == OCC_W'(DEPTH));
  assign stat.head_due = (occ != '0) && (slot_dl[0] <= in_now);
  assign stat.next_due = (occ > OCC_W'(1)) && (slot_dl[1] <= in_now);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      in_dl  <= deadline[TW-1:0];
      in_now <= now_time[TW-1:0];
      in_hnd <= handle;
    end
    if (ctl.cmp) begin
      le <= le_next;
    end
  end

  // Each cell keeps, takes the new entry, or takes its neighbour
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (ctl.insert && !le[g]) begin
        if (g == 0) begin
          slot_dl[g]  <= in_dl;
          slot_hnd[g] <= in_hnd;
          slot_id[g]  <= nid;
        end else if (le[(g == 0) ? 0 : g - 1]) begin
          slot_dl[g]  <= in_dl;
          slot_hnd[g] <= in_hnd;
          slot_id[g]  <= nid;
        end else begin
          slot_dl[g]  <= slot_dl[(g == 0) ? 0 : g - 1];
          slot_hnd[g] <= slot_hnd[(g == 0) ? 0 : g - 1];
          slot_id[g]  <= slot_id[(g == 0) ? 0 : g - 1];
        end
      end else if (ctl.pop && (g < DEPTH - 1)) begin
        slot_dl[g]  <= slot_dl[(g < DEPTH - 1) ? g + 1 : g];
        slot_hnd[g] <= slot_hnd[(g < DEPTH - 1) ? g + 1 : g];
        slot_id[g]  <= slot_id[(g < DEPTH - 1) ? g + 1 : g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ        <= '0;
      id_counter <= '0;
    end else if (ctl.insert) begin
      occ        <= occ + OCC_W'(1);
      id_counter <= nid;
    end else if (ctl.pop) begin
      occ        <= occ - OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.insert | ctl.reject | ctl.pop | ctl.none_due;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      kind          <= KIND_ADDED;
      entry_id      <= nid;
      entry_handle  <= '0;
      next_deadline <= le[0] ? ND_W'(slot_dl[0]) : ND_W'(in_dl);
      last          <= 1'b1;
    end else if (ctl.pop) begin
      kind          <= KIND_DUE;
      entry_id      <= slot_id[0];
      entry_handle  <= slot_hnd[0];
      next_deadline <= second_nd;
      last          <= ctl.pop_last;
    end else if (ctl.reject || ctl.none_due) begin
      kind          <= ctl.reject ? KIND_FULL : KIND_NONE;
      entry_id      <= '0;
      entry_handle  <= '0;
      next_deadline <= head_nd;
      last          <= 1'b1;
    end
  end

endmodule

### sv/dstq_ctrl.sv
module dstq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                cmd,
  input  dstq_pkg::dp_stat_t  stat,
  output dstq_pkg::dp_cmd_t   ctl,
  output logic                busy
);
  import dstq_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic             can_pop;
  logic             more_after;

  assign can_pop    = stat.head_due && (count < CNT_W'(MAX_OUT));
  assign more_after = stat.next_due && (count < CNT_W'(MAX_OUT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        count <= '0;
      end else if (ctl.pop) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (cmd == CMD_ADD) ? ST_ADD_CMP : ST_POLL;
        end
      end
      ST_ADD_CMP: begin
        state_next = stat.full ? ST_IDLE : ST_ADD_INS;
      end
      ST_ADD_INS: begin
        state_next = ST_IDLE;
      end
      ST_POLL: begin
        if (!can_pop || !more_after) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
      end
      ST_ADD_CMP: begin
        ctl.reject = stat.full;
        ctl.cmp    = !stat.full;
      end
      ST_ADD_INS: begin
        ctl.insert = 1'b1;
      end
      ST_POLL: begin
        ctl.pop      = can_pop;
        ctl.pop_last = !more_after;
        ctl.none_due = !can_pop;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

### sv/dstq_checker.sv
module dstq_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        strobe,
  input logic [1:0]  kind,
  input logic [30:0] entry_id,
  input logic [15:0] entry_handle,
  input logic        last
);
  import dstq_pkg::*;

  // Every accepted item raises busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted item");

  // Only a due entry may be followed by further results of the same item
  a_not_last_due: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> kind == KIND_DUE)
    else $error("non-final result is not a due entry");

  // Due entries of one poll come out in consecutive cycles
  a_drain_gapless: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe && kind == KIND_DUE)
    else $error("gap in the drain of due entries");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("result straight after a final result");

  a_id_rules: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ((kind == KIND_ADDED) ? (entry_id != '0 && entry_handle == '0)
              : (kind == KIND_DUE) ? 1'b1
              : (entry_id == '0 && entry_handle == '0)))
    else $error("id or handle wrong for the result kind");

endmodule

bind deadline_sorted_timer_queue_top dstq_checker u_dstq_checker (.*);
